// ----- design/rmth_pkg.sv -----
// Shared types and constants for the two-heap running median block.
// No dependencies.
`default_nettype none
package rmth_pkg;
    localparam int CAPACITY_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int IN_W            = 16;
    localparam int MED_W           = 17;

    // datapath commands
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_PUSH  = 3'd1;
    localparam logic [2:0] OP_REPL  = 3'd2;

    typedef struct packed {
        logic       load;
        logic [2:0] op;
        logic       sel_upper;
        logic       use_carry;
        logic       save_top;
        logic       finish;
    } rmth_cmd_t;

    typedef struct packed {
        logic ready;
        logic lower_empty;
        logic upper_empty;
        logic full;
        logic ge_upper;
        logic le_lower;
        logic ge_lower;
        logic upper_le_lower;
        logic lower_le_upper;
    } rmth_sts_t;
endpackage
`default_nettype wire

// ----- design/rmth_heap.sv -----
// One binary heap in a memory with one write and one read port, with a sift sequencer.
// Depends on rmth_pkg.
`default_nettype none
module rmth_heap #(
    parameter int DEPTH = 512,
    parameter int SB    = 16,
    parameter bit IS_MAX = 1'b1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic              repl,
    input  wire logic [SB-1:0]     val,
    output logic                   idle,
    output logic [SB-1:0]          top,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import rmth_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);
    localparam logic [2:0] S_IDLE = 3'd0, S_UPRD = 3'd1, S_UPCMP = 3'd2,
        S_DNRDL = 3'd3, S_DNRDR = 3'd4, S_DNCMP = 3'd5, S_UPTOP = 3'd6;

    logic [SB-1:0] mem [DEPTH];
    logic [2:0]    st_reg, st_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW:0]   i_reg, i_next;
    logic [SB-1:0] v_reg, v_next, top_reg, top_next;
    logic [SB-1:0] rd_reg, l_reg, l_next;
    logic [CW:0]   p, lc, rc, c;
    logic          we;
    logic [AW-1:0] wa, ra;
    logic [SB-1:0] wd;
    logic          l_better, c_better;

    function automatic logic above(input logic [SB-1:0] a, input logic [SB-1:0] b);
        return IS_MAX ? (a > b) : (a < b);
    endfunction

    assign p  = (i_reg - 1'b1) >> 1;
    assign lc = {i_reg[CW-1:0], 1'b1};
    assign rc = lc + 1'b1;
    assign l_better = above(rd_reg, l_reg);
    assign c_better = (rc < {1'b0, cnt_reg}) && l_better;

    always_comb
    begin
        st_next = st_reg; cnt_next = cnt_reg; i_next = i_reg; v_next = v_reg;
        top_next = top_reg; l_next = l_reg;
        we = 1'b0; wa = '0; wd = v_reg; ra = '0; c = lc;
        case (st_reg)
            S_IDLE:
            begin
                if (push)
                begin
                    we = 1'b1; wa = cnt_reg[AW-1:0]; wd = val;
                    v_next = val; i_next = {1'b0, cnt_reg};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == '0)
                        top_next = val;
                    else
                        st_next = S_UPRD;
                end
                else if (repl)
                begin
                    we = 1'b1; wa = '0; wd = val; v_next = val; i_next = '0;
                    top_next = val; st_next = S_DNRDL;
                end
            end
            S_UPRD:
            begin
                ra = p[AW-1:0]; st_next = S_UPCMP;
            end
            S_UPCMP:
            begin
                if (above(v_reg, rd_reg))
                begin
                    we = 1'b1; wa = i_reg[AW-1:0]; wd = rd_reg;
                    i_next = p;
                    if (p == '0)
                        st_next = S_UPTOP;
                    else
                        st_next = S_UPRD;
                end
                else
                begin
                    we = 1'b1; wa = i_reg[AW-1:0]; wd = v_reg; st_next = S_IDLE;
                end
            end
            S_UPTOP:
            begin
                we = 1'b1; wa = '0; wd = v_reg;
                top_next = v_reg; st_next = S_IDLE;
            end
            S_DNRDL:
            begin
                if (lc >= {1'b0, cnt_reg})
                begin
                    we = 1'b1; wa = i_reg[AW-1:0]; wd = v_reg;
                    if (i_reg == '0) top_next = v_reg;
                    st_next = S_IDLE;
                end
                else
                begin
                    ra = lc[AW-1:0]; st_next = S_DNRDR;
                end
            end
            S_DNRDR:
            begin
                l_next = rd_reg; ra = rc[AW-1:0]; st_next = S_DNCMP;
            end
            S_DNCMP:
            begin
                c = c_better ? rc : lc;
                if (above(c_better ? rd_reg : l_reg, v_reg))
                begin
                    we = 1'b1; wa = i_reg[AW-1:0];
                    wd = c_better ? rd_reg : l_reg;
                    if (i_reg == '0) top_next = wd;
                    i_next = c; st_next = S_DNRDL;
                end
                else
                begin
                    we = 1'b1; wa = i_reg[AW-1:0]; wd = v_reg;
                    if (i_reg == '0) top_next = v_reg;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we) mem[wa] <= wd;
        rd_reg <= mem[ra];
        v_reg <= v_next; i_reg <= i_next; l_reg <= l_next; top_reg <= top_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next; cnt_reg <= cnt_next;
        end
    end

    assign idle  = (st_reg == S_IDLE);
    assign top   = top_reg;
    assign count = cnt_reg;
endmodule
`default_nettype wire

// ----- design/rmth_datapath.sv -----
// Datapath: both heaps, the sample and carried-top registers, median adder.
// Depends on rmth_pkg and rmth_heap.
`default_nettype none
module rmth_datapath #(
    parameter int CAPACITY    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [rmth_pkg::IN_W-1:0] sample,
    input  wire rmth_pkg::rmth_cmd_t  cmd,
    output rmth_pkg::rmth_sts_t       sts,
    output logic [rmth_pkg::MED_W-1:0] median_x2,
    output logic                      store_full
);
    import rmth_pkg::*;
    localparam int DEPTH = (CAPACITY + 1) / 2;
    localparam int CW = $clog2(DEPTH+1);
    localparam int SB = SAMPLE_BITS;

    logic [SB-1:0] s_reg, t_reg, val, lo_top, up_top;
    logic [CW-1:0] lo_cnt, up_cnt;
    logic          lo_idle, up_idle;
    logic [MED_W-1:0] med_reg, med_next;
    logic          full_reg;
    logic [SB:0]   sum;

    assign val = cmd.use_carry ? t_reg : s_reg;

    rmth_heap #(.DEPTH(DEPTH), .SB(SB), .IS_MAX(1'b1)) u_lo (
        .clk(clk), .rst_n(rst_n),
        .push(!cmd.sel_upper && cmd.op == OP_PUSH),
        .repl(!cmd.sel_upper && cmd.op == OP_REPL),
        .val(val), .idle(lo_idle), .top(lo_top), .count(lo_cnt));
    rmth_heap #(.DEPTH(DEPTH), .SB(SB), .IS_MAX(1'b0)) u_up (
        .clk(clk), .rst_n(rst_n),
        .push(cmd.sel_upper && cmd.op == OP_PUSH),
        .repl(cmd.sel_upper && cmd.op == OP_REPL),
        .val(val), .idle(up_idle), .top(up_top), .count(up_cnt));

    always_comb
    begin
        sum = '0;
        if (lo_cnt == up_cnt)
            sum = {1'b0, lo_top} + {1'b0, up_top};
        else if (up_cnt > lo_cnt)
            sum = {up_top, 1'b0};
        else
            sum = {lo_top, 1'b0};
        if (lo_cnt == '0 && up_cnt == '0)
            sum = '0;
        med_next = MED_W'(sum);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) s_reg <= sample[SB-1:0];
        if (cmd.save_top) t_reg <= cmd.sel_upper ? up_top : lo_top;
        if (cmd.finish) med_reg <= med_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (cmd.load)
            full_reg <= (32'(lo_cnt) + 32'(up_cnt)) >= 32'(CAPACITY);
    end

    assign sts.ready       = lo_idle && up_idle;
    assign sts.lower_empty = (lo_cnt == '0);
    assign sts.upper_empty = (up_cnt == '0);
    assign sts.full        = full_reg;
    assign sts.ge_upper    = (s_reg >= up_top);
    assign sts.le_lower    = (s_reg <= lo_top);
    assign sts.ge_lower    = (s_reg >= lo_top);
    assign sts.upper_le_lower = (up_cnt <= lo_cnt);
    assign sts.lower_le_upper = (lo_cnt <= up_cnt);
    assign median_x2  = med_reg;
    assign store_full = full_reg;
endmodule
`default_nettype wire

// ----- design/rmth_ctrl.sv -----
// Controller: picks the heap operations for each insert and sequences them.
// Depends on rmth_pkg.
`default_nettype none
module rmth_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    output logic                     done,
    output rmth_pkg::rmth_cmd_t      cmd,
    input  wire rmth_pkg::rmth_sts_t sts
);
    import rmth_pkg::*;
    localparam logic [2:0] C_IDLE = 3'd0, C_DEC = 3'd1, C_WAIT1 = 3'd2,
        C_SECOND = 3'd3, C_WAIT2 = 3'd4, C_FIN = 3'd5;

    logic [2:0] st_reg, st_next;
    logic       two_reg, two_next, up_reg, up_next;
    logic       done_reg;

    always_comb
    begin
        st_next = st_reg; two_next = two_reg; up_next = up_reg;
        cmd = '0;
        case (st_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1; st_next = C_DEC;
                end
            end
            C_DEC:
            begin
                if (sts.full)
                    st_next = C_FIN;
                else
                begin
                    st_next = C_WAIT1; two_next = 1'b0; up_next = 1'b0;
                    if (sts.lower_empty)
                        cmd.op = OP_PUSH;
                    else if (sts.upper_empty)
                    begin
                        if (sts.ge_lower)
                        begin
                            cmd.op = OP_PUSH; cmd.sel_upper = 1'b1;
                        end
                        else
                        begin
                            cmd.op = OP_REPL; cmd.save_top = 1'b1;
                            cmd.sel_upper = 1'b0; two_next = 1'b1; up_next = 1'b1;
                        end
                    end
                    else if (sts.ge_upper)
                    begin
                        if (sts.upper_le_lower)
                        begin
                            cmd.op = OP_PUSH; cmd.sel_upper = 1'b1;
                        end
                        else
                        begin
                            cmd.op = OP_REPL; cmd.sel_upper = 1'b1;
                            two_next = 1'b1; up_next = 1'b0;
                        end
                    end
                    else if (sts.le_lower)
                    begin
                        if (sts.lower_le_upper)
                            cmd.op = OP_PUSH;
                        else
                        begin
                            cmd.op = OP_REPL; two_next = 1'b1; up_next = 1'b1;
                        end
                    end
                    else if (sts.lower_le_upper)
                        cmd.op = OP_PUSH;
                    else
                    begin
                        cmd.op = OP_PUSH; cmd.sel_upper = 1'b1;
                    end
                    // capture the displaced top before it is overwritten
                    if (two_next)
                    begin
                        cmd.save_top = 1'b1; cmd.sel_upper = !up_next;
                    end
                end
            end
            C_WAIT1:
                if (sts.ready) st_next = two_reg ? C_SECOND : C_FIN;
            C_SECOND:
            begin
                cmd.op = OP_PUSH; cmd.sel_upper = up_reg; cmd.use_carry = 1'b1;
                st_next = C_WAIT2;
            end
            C_WAIT2:
                if (sts.ready) st_next = C_FIN;
            C_FIN:
            begin
                cmd.finish = 1'b1; st_next = C_IDLE;
            end
            default: st_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= C_IDLE; two_reg <= 1'b0; up_reg <= 1'b0; done_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; two_reg <= two_next; up_reg <= up_next;
            done_reg <= (st_reg == C_FIN);
        end
    end

    assign busy = (st_reg != C_IDLE);
    assign done = done_reg;
endmodule
`default_nettype wire

// ----- design/running_median_two_heaps.sv -----
// Running median over two heaps: one sample word in, one median word out.
// Time from accept to done depends on the path: a full store skips the heaps, and otherwise
// the heap sifts set it, down for a replace and up for a push.
// One sample at a time: busy stays high until done pulses; the next accept may share that cycle.
// Reset clears heap counts and control; heap memories are not cleared.
// Depends on rmth_pkg, rmth_ctrl, rmth_datapath.
`default_nettype none
module running_median_two_heaps #(
    parameter int CAPACITY    = rmth_pkg::CAPACITY_DEF,
    parameter int SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [rmth_pkg::IN_W-1:0]  sample,
    output logic                            done,
    output logic [rmth_pkg::MED_W-1:0]      median_x2,
    output logic                            store_full
);
    import rmth_pkg::*;
    rmth_cmd_t cmd;
    rmth_sts_t sts;

    rmth_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .done(done), .cmd(cmd), .sts(sts));
    rmth_datapath #(.CAPACITY(CAPACITY), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .sample(sample), .cmd(cmd), .sts(sts),
        .median_x2(median_x2), .store_full(store_full));

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
endmodule
`default_nettype wire

// ----- test/rmth_checker.sv -----
// Checker for the two-heap running median block: predicts each median word.
// Depends on rmth_pkg; instantiated beside the block by tb_running_median_two_heaps.
`timescale 1ns / 100ps
module rmth_checker #(
    parameter int CAPACITY    = rmth_pkg::CAPACITY_DEF,
    parameter int SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic [rmth_pkg::IN_W-1:0]  sample,
    input  wire logic                       done,
    input  wire logic [rmth_pkg::MED_W-1:0] median_x2,
    input  wire logic                       store_full,
    output int                              errors,
    output int                              pending
);
    localparam int DEPTH = (CAPACITY + 1) / 2;

    typedef struct packed {
        logic [rmth_pkg::MED_W-1:0] median;
        logic                       full;
    } median_word_t;

    logic [31:0]  lo_heap [DEPTH];
    logic [31:0]  hi_heap [DEPTH];
    int           lo_cnt;
    int           hi_cnt;
    median_word_t median_q[$];

    function automatic bit outranks(logic [31:0] a, logic [31:0] b, bit is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic push_heap(bit upper, logic [31:0] v);
        int          i;
        int          p;
        logic [31:0] t;
        i = upper ? hi_cnt : lo_cnt;
        if (i >= DEPTH)
            return;
        if (upper)
        begin
            hi_heap[i] = v;
            hi_cnt = i + 1;
        end
        else
        begin
            lo_heap[i] = v;
            lo_cnt = i + 1;
        end
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (upper ? outranks(hi_heap[i], hi_heap[p], 0)
                      : outranks(lo_heap[i], lo_heap[p], 1))
            begin
                if (upper)
                begin
                    t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t;
                end
                else
                begin
                    t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t;
                end
                i = p;
            end
            else
                break;
        end
    endtask

    task automatic replace_top(bit upper, logic [31:0] v);
        int          i;
        int          l;
        int          c;
        int          n;
        logic [31:0] t;
        i = 0;
        n = upper ? hi_cnt : lo_cnt;
        if (upper) hi_heap[0] = v; else lo_heap[0] = v;
        forever
        begin
            l = 2 * i + 1;
            if (l >= n)
                break;
            c = l;
            if (upper)
            begin
                if (l + 1 < n && outranks(hi_heap[l+1], hi_heap[l], 0)) c = l + 1;
                if (!outranks(hi_heap[c], hi_heap[i], 0)) break;
                t = hi_heap[c]; hi_heap[c] = hi_heap[i]; hi_heap[i] = t;
            end
            else
            begin
                if (l + 1 < n && outranks(lo_heap[l+1], lo_heap[l], 1)) c = l + 1;
                if (!outranks(lo_heap[c], lo_heap[i], 1)) break;
                t = lo_heap[c]; lo_heap[c] = lo_heap[i]; lo_heap[i] = t;
            end
            i = c;
        end
    endtask

    task automatic add_sample(logic [31:0] s);
        logic [31:0] t;
        if (lo_cnt == 0)
            push_heap(0, s);
        else if (hi_cnt == 0)
        begin
            if (s >= lo_heap[0])
                push_heap(1, s);
            else
            begin
                t = lo_heap[0]; replace_top(0, s); push_heap(1, t);
            end
        end
        else if (s >= hi_heap[0])
        begin
            if (hi_cnt <= lo_cnt)
                push_heap(1, s);
            else
            begin
                t = hi_heap[0]; replace_top(1, s); push_heap(0, t);
            end
        end
        else if (s <= lo_heap[0])
        begin
            if (lo_cnt <= hi_cnt)
                push_heap(0, s);
            else
            begin
                t = lo_heap[0]; replace_top(0, s); push_heap(1, t);
            end
        end
        else if (lo_cnt <= hi_cnt)
            push_heap(0, s);
        else
            push_heap(1, s);
    endtask

    task automatic predict_median(logic [rmth_pkg::IN_W-1:0] raw);
        median_word_t w;
        logic [63:0]  m;
        w.full = (lo_cnt + hi_cnt) >= CAPACITY;
        if (!w.full)
            add_sample(32'(raw) & 32'((64'd1 << SAMPLE_BITS) - 1));
        if (lo_cnt == 0 && hi_cnt == 0)
            m = 0;
        else if (lo_cnt == hi_cnt)
            m = 64'(lo_heap[0]) + 64'(hi_heap[0]);
        else if (hi_cnt > lo_cnt)
            m = 2 * 64'(hi_heap[0]);
        else
            m = 2 * 64'(lo_heap[0]);
        w.median = m[rmth_pkg::MED_W-1:0];
        median_q = {median_q, w};
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
        lo_cnt  = 0;
        hi_cnt  = 0;
    end

    always @(posedge clk)
    begin
        median_word_t exp_w;
        if (rst_n)
        begin
            if (done)
            begin
                if (median_q.size() == 0)
                begin
                    $display("%0t: unexpected word median_x2=%0d store_full=%0b",
                             $time, median_x2, store_full);
                    errors++;
                end
                else
                begin
                    exp_w = median_q.pop_front();
                    if (median_x2 !== exp_w.median)
                    begin
                        $display("%0t: median_x2 expected %0d actual %0d",
                                 $time, exp_w.median, median_x2);
                        errors++;
                    end
                    if (store_full !== exp_w.full)
                    begin
                        $display("%0t: store_full expected %0b actual %0b",
                                 $time, exp_w.full, store_full);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                predict_median(sample);
            pending = median_q.size();
        end
    end
endmodule

// ----- test/tb_running_median_two_heaps.sv -----
// Testbench top for running_median_two_heaps: drives samples through phases of idling.
// Depends on rmth_pkg, the block and rmth_checker.
`timescale 1ns / 100ps
module tb_running_median_two_heaps;
    localparam int CAP       = 1024;
    localparam int MAX_CYCLE = 2_000_000;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [rmth_pkg::IN_W-1:0]  sample;
    logic                       done;
    logic [rmth_pkg::MED_W-1:0] median_x2;
    logic                       store_full;
    int                         errors;
    int                         pending;
    int                         cycle;
    int                         gap_pct;

    running_median_two_heaps #(.CAPACITY(CAP), .SAMPLE_BITS(16)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .done(done), .median_x2(median_x2), .store_full(store_full)
    );

    rmth_checker #(.CAPACITY(CAP), .SAMPLE_BITS(16)) checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .done(done), .median_x2(median_x2), .store_full(store_full),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // hold start until the word is taken; the next call sets start again
    task automatic send_word(logic [15:0] v);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 0;
            @(negedge clk);
        end
        start  <= 1;
        sample <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(7) + 100);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int k;
        cycle   = 0;
        start   = 0;
        sample  = 0;
        gap_pct = 0;
        rst_n   = 0;
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        // extremes, ties on both tops, alternation of sides
        send_word(16'h8000);
        send_word(16'h8000);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h8000);
        send_word(16'h7FFF);
        send_word(16'h8001);
        send_word(16'h0001);
        send_word(16'hFFFE);
        send_word(16'h5555);
        send_word(16'hAAAA);
        send_word(16'h8000);
        // advance through idling phases
        for (k = 0; k < 490; k++)
        begin
            case (k / 98)
                0: gap_pct = 0;
                1: gap_pct = 85;
                2: gap_pct = 0;
                3: gap_pct = 6;
                default: gap_pct = 50;
            endcase
            if (k == 300)
            begin
                start <= 0;
                while (pending != 0)
                    @(negedge clk);
            end
            send_word(rand_sample());
        end
        start <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
